@@ rtl/sfc_pkg.sv @@
// Shared types, constants and the CRC helper for the SPI frame checker.
package sfc_pkg;

  localparam int unsigned FRAME_WORDS_DEF = 17;
  localparam int unsigned COUNT_BITS_DEF  = 32;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned REG_HEADER  = 0;
  localparam int unsigned REG_VERSION = 1;

  localparam logic [15:0] HEADER_RESET  = 16'h55AA;
  localparam logic [15:0] VERSION_RESET = 16'h0001;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int unsigned REF_WORDS = 7;
  localparam int unsigned OUT_DATA_W = 352;

  typedef enum logic [1:0] {
    FUNC_WORD    = 2'd0,
    FUNC_CS_FALL = 2'd1,
    FUNC_CS_RISE = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_HEADER  = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_CRC_ERROR   = 3'd3,
    ST_SHORT_FRAME = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] header;
    logic [15:0] version;
  } cfg_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/sfc_cfg_regs.sv @@
// APB register file holding the expected header and version words.
module sfc_cfg_regs
  import sfc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [15:0] header_q, header_d;
  logic [15:0] version_q, version_d;
  logic        reg_sel;
  logic        wr_en;

  // Registers sit on 32-bit word boundaries; the low address bits are ignored.
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    header_d  = header_q;
    version_d = version_q;
    if (wr_en) begin
      if (reg_sel == 1'(REG_HEADER)) begin
        header_d = pwdata[15:0];
      end else begin
        version_d = pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= HEADER_RESET;
      version_q <= VERSION_RESET;
    end else begin
      header_q  <= header_d;
      version_q <= version_d;
    end
  end

  always_comb begin
    if (reg_sel == 1'(REG_VERSION)) begin
      prdata = {16'h0000, version_q};
    end else begin
      prdata = {16'h0000, header_q};
    end
  end

  assign cfg_o.header  = header_q;
  assign cfg_o.version = version_q;

endmodule

@@ rtl/spi_frame_checker_crc16.sv @@
// Top level of the SPI frame checker with CRC-16/CCITT-FALSE.
// Each input item is a chip-select edge or a received SPI word; a falling edge
// opens a frame, words are checked on arrival, and the rising edge that closes
// an open frame yields one result item with the status, the captured command
// and reference words (zero unless the frame is good) and the event counters.
// Repeated edges, words outside a frame, words past FRAME_WORDS and the unused
// kind code yield no result. The block takes one item every clock cycle unless
// the receiver stalls a full result register; an item passes an input register
// and is processed into the result register when that can advance. The rate is
// set by the per-word CRC update, which folds both bytes of a word combinationally.
module spi_frame_checker_crc16
  import sfc_pkg::*;
#(
  parameter int unsigned FRAME_WORDS = FRAME_WORDS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] word
  input  logic [1:0]            s_axis_tuser,   // [1:0] func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] command, then ref_a .. ref_f, format_error_total, crc_error_total,
  // good_frame_total, ignored_edge_total, 32 bits each
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [2:0]            m_axis_tuser,   // [2:0] status
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W = $clog2(FRAME_WORDS + 1);

  cfg_t cfg;

  sfc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register
  logic        in_valid_q, in_valid_d;
  logic [1:0]  func_q, func_d;
  logic [15:0] word_q, word_d;
  logic        advance;
  logic        process;

  // Frame state
  logic                  open_q, open_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [15:0]           crc_q, crc_d;
  logic                  hdr_bad_q, hdr_bad_d;
  logic                  ver_bad_q, ver_bad_d;
  logic                  crc_bad_q, crc_bad_d;
  logic [REF_WORDS-1:0][31:0] cap_q, cap_d;
  logic [COUNT_BITS-1:0] fmt_cnt_q, fmt_cnt_d;
  logic [COUNT_BITS-1:0] crc_cnt_q, crc_cnt_d;
  logic [COUNT_BITS-1:0] good_cnt_q, good_cnt_d;
  logic [COUNT_BITS-1:0] ign_cnt_q, ign_cnt_d;

  // Result register
  logic                  out_valid_q, out_valid_d;
  logic [2:0]            out_status_q, out_status_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  status_e status;
  logic    emit;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign process       = in_valid_q && advance;

  always_comb begin
    in_valid_d = in_valid_q;
    func_d     = func_q;
    word_d     = word_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
      func_d     = s_axis_tuser;
      word_d     = s_axis_tdata;
    end
  end

  always_comb begin
    if (hdr_bad_q) begin
      status = ST_BAD_HEADER;
    end else if (ver_bad_q) begin
      status = ST_BAD_VERSION;
    end else if (idx_q < IDX_W'(FRAME_WORDS)) begin
      status = ST_SHORT_FRAME;
    end else if (crc_bad_q) begin
      status = ST_CRC_ERROR;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    open_d     = open_q;
    idx_d      = idx_q;
    crc_d      = crc_q;
    hdr_bad_d  = hdr_bad_q;
    ver_bad_d  = ver_bad_q;
    crc_bad_d  = crc_bad_q;
    cap_d      = cap_q;
    fmt_cnt_d  = fmt_cnt_q;
    crc_cnt_d  = crc_cnt_q;
    good_cnt_d = good_cnt_q;
    ign_cnt_d  = ign_cnt_q;
    emit       = 1'b0;
    if (process) begin
      case (func_e'(func_q))
        FUNC_WORD: begin
          if (open_q && (idx_q < IDX_W'(FRAME_WORDS))) begin
            if (idx_q == IDX_W'(0)) begin
              hdr_bad_d = (word_q != cfg.header);
            end
            if (idx_q == IDX_W'(1)) begin
              ver_bad_d = (word_q != cfg.version);
            end
            for (int k = 0; k < REF_WORDS; k++) begin
              if (idx_q == IDX_W'(2 * k + 2)) begin
                cap_d[k][15:0] = word_q;
              end
              if (idx_q == IDX_W'(2 * k + 3)) begin
                cap_d[k][31:16] = word_q;
              end
            end
            if (idx_q < IDX_W'(FRAME_WORDS - 1)) begin
              crc_d = crc16_byte(crc16_byte(crc_q, word_q[15:8]), word_q[7:0]);
            end else begin
              crc_bad_d = (crc_q != word_q);
            end
            idx_d = idx_q + IDX_W'(1);
          end
        end
        FUNC_CS_FALL: begin
          if (open_q) begin
            ign_cnt_d = ign_cnt_q + COUNT_BITS'(1);
          end else begin
            open_d    = 1'b1;
            idx_d     = '0;
            crc_d     = CRC_INIT;
            hdr_bad_d = 1'b0;
            ver_bad_d = 1'b0;
            crc_bad_d = 1'b0;
          end
        end
        FUNC_CS_RISE: begin
          if (!open_q) begin
            ign_cnt_d = ign_cnt_q + COUNT_BITS'(1);
          end else begin
            open_d = 1'b0;
            emit   = 1'b1;
            if (status == ST_OK) begin
              good_cnt_d = good_cnt_q + COUNT_BITS'(1);
            end else if (status == ST_CRC_ERROR) begin
              crc_cnt_d = crc_cnt_q + COUNT_BITS'(1);
            end else begin
              fmt_cnt_d = fmt_cnt_q + COUNT_BITS'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d  = 1'b1;
      out_status_d = status;
      for (int k = 0; k < REF_WORDS; k++) begin
        out_data_d[32*k +: 32] = (status == ST_OK) ? cap_q[k] : 32'h0;
      end
      out_data_d[32*REF_WORDS       +: 32] = 32'(fmt_cnt_d);
      out_data_d[32*(REF_WORDS + 1) +: 32] = 32'(crc_cnt_d);
      out_data_d[32*(REF_WORDS + 2) +: 32] = 32'(good_cnt_d);
      out_data_d[32*(REF_WORDS + 3) +: 32] = 32'(ign_cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      open_q      <= 1'b0;
      idx_q       <= '0;
      crc_q       <= CRC_INIT;
      hdr_bad_q   <= 1'b0;
      ver_bad_q   <= 1'b0;
      crc_bad_q   <= 1'b0;
      fmt_cnt_q   <= '0;
      crc_cnt_q   <= '0;
      good_cnt_q  <= '0;
      ign_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      open_q      <= open_d;
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      hdr_bad_q   <= hdr_bad_d;
      ver_bad_q   <= ver_bad_d;
      crc_bad_q   <= crc_bad_d;
      fmt_cnt_q   <= fmt_cnt_d;
      crc_cnt_q   <= crc_cnt_d;
      good_cnt_q  <= good_cnt_d;
      ign_cnt_q   <= ign_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    word_q       <= word_d;
    cap_q        <= cap_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ dv/sfc_report_checker.sv @@
// Checker for the SPI frame checker: predicts frame reports and compares them.
module sfc_report_checker
  import sfc_pkg::*;
#(
  parameter int unsigned FRAME_WORDS = FRAME_WORDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [15:0]           s_data_i,
  input  logic [1:0]            s_user_i,
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [OUT_DATA_W-1:0] m_data_i,
  input  logic [2:0]            m_user_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_ADDR_W-1:0] ADDR_HEADER  = APB_ADDR_W'(REG_HEADER * 4);
  localparam logic [APB_ADDR_W-1:0] ADDR_VERSION = APB_ADDR_W'(REG_VERSION * 4);
  localparam int unsigned           MAX_PRINTS   = 50;

  typedef struct packed {
    status_e                 status;
    logic [OUT_DATA_W-1:0]   fields;
  } frame_report_t;

  logic [15:0]   header_cfg;
  logic [15:0]   version_cfg;
  logic          in_frame;
  int unsigned   word_pos;
  logic [15:0]   crc_acc;
  logic          header_wrong;
  logic          version_wrong;
  logic          crc_wrong;
  logic [31:0]   captured [REF_WORDS];
  logic [31:0]   format_errs;
  logic [31:0]   crc_errs;
  logic [31:0]   good_frames;
  logic [31:0]   ignored_edges;
  frame_report_t pending_reports [$];

  // Bit-serial form of the CRC, MSB of the word first.
  function automatic logic [15:0] crc_fold_word(input logic [15:0] crc,
                                                input logic [15:0] w);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int b = 15; b >= 0; b--) begin
      fb = c[15] ^ w[b];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic string field_label(input int k);
    case (k)
      0:       return "command";
      1:       return "ref_a";
      2:       return "ref_b";
      3:       return "ref_c";
      4:       return "ref_d";
      5:       return "ref_e";
      6:       return "ref_f";
      7:       return "format_error_total";
      8:       return "crc_error_total";
      9:       return "good_frame_total";
      default: return "ignored_edge_total";
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count_o < MAX_PRINTS) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    fail_count_o++;
  endtask

  task automatic predict_item(input logic [1:0] kind, input logic [15:0] w);
    frame_report_t rep;
    status_e       st;
    int unsigned   slot;
    case (kind)
      FUNC_WORD: begin
        // Words outside a frame or past its length leave no trace.
        if (in_frame && word_pos < FRAME_WORDS) begin
          if (word_pos == 0) begin
            header_wrong = (w != header_cfg);
          end
          if (word_pos == 1) begin
            version_wrong = (w != version_cfg);
          end
          if (word_pos >= 2 && word_pos <= 15) begin
            slot = (word_pos - 2) >> 1;
            if (word_pos[0]) begin
              captured[slot][31:16] = w;
            end else begin
              captured[slot][15:0] = w;
            end
          end
          if (word_pos < FRAME_WORDS - 1) begin
            crc_acc = crc_fold_word(crc_acc, w);
          end else begin
            crc_wrong = (crc_acc != w);
          end
          word_pos++;
        end
      end
      FUNC_CS_FALL: begin
        if (in_frame) begin
          ignored_edges++;
        end else begin
          in_frame      = 1'b1;
          word_pos      = 0;
          crc_acc       = CRC_INIT;
          header_wrong  = 1'b0;
          version_wrong = 1'b0;
          crc_wrong     = 1'b0;
        end
      end
      FUNC_CS_RISE: begin
        if (!in_frame) begin
          ignored_edges++;
        end else begin
          in_frame = 1'b0;
          if (header_wrong) begin
            st = ST_BAD_HEADER;
          end else if (version_wrong) begin
            st = ST_BAD_VERSION;
          end else if (word_pos < FRAME_WORDS) begin
            st = ST_SHORT_FRAME;
          end else if (crc_wrong) begin
            st = ST_CRC_ERROR;
          end else begin
            st = ST_OK;
          end
          case (st)
            ST_OK:        good_frames++;
            ST_CRC_ERROR: crc_errs++;
            default:      format_errs++;
          endcase
          rep.status = st;
          rep.fields = '0;
          if (st == ST_OK) begin
            for (int k = 0; k < REF_WORDS; k++) begin
              rep.fields[32*k +: 32] = captured[k];
            end
          end
          rep.fields[32*7 +: 32]  = format_errs;
          rep.fields[32*8 +: 32]  = crc_errs;
          rep.fields[32*9 +: 32]  = good_frames;
          rep.fields[32*10 +: 32] = ignored_edges;
          pending_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_report_t want;
    if (!rst_ni) begin
      header_cfg    = HEADER_RESET;
      version_cfg   = VERSION_RESET;
      in_frame      = 1'b0;
      word_pos      = 0;
      crc_acc       = CRC_INIT;
      header_wrong  = 1'b0;
      version_wrong = 1'b0;
      crc_wrong     = 1'b0;
      format_errs   = '0;
      crc_errs      = '0;
      good_frames   = '0;
      ignored_edges = '0;
      for (int k = 0; k < REF_WORDS; k++) begin
        captured[k] = '0;
      end
      pending_reports.delete();
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i)
          ADDR_HEADER:  header_cfg  = pwdata_i[15:0];
          ADDR_VERSION: version_cfg = pwdata_i[15:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        predict_item(s_user_i, s_data_i);
      end
      if (m_valid_i && m_ready_i) begin
        if (pending_reports.size() == 0) begin
          report_mismatch($sformatf("result item with status %0d and nothing expected",
                                    m_user_i));
        end else begin
          want = pending_reports.pop_front();
          if (m_user_i != want.status) begin
            report_mismatch($sformatf("report %0d status got %0d expected %0d",
                                      checked_o, m_user_i, want.status));
          end
          for (int k = 0; k < 11; k++) begin
            if (m_data_i[32*k +: 32] != want.fields[32*k +: 32]) begin
              report_mismatch($sformatf("report %0d %s got %h expected %h", checked_o,
                                        field_label(k), m_data_i[32*k +: 32],
                                        want.fields[32*k +: 32]));
            end
          end
        end
        checked_o++;
      end
      pending_o = pending_reports.size();
    end
  end

endmodule

@@ dv/tb_spi_frame_checker_crc16.sv @@
// Testbench top for the SPI frame checker: clock, reset, stimulus and verdict.
module tb_spi_frame_checker_crc16;
  timeunit 1ns;
  timeprecision 1ps;
  import sfc_pkg::*;

  localparam int unsigned           FW            = FRAME_WORDS_DEF;
  localparam logic [1:0]            FUNC_UNUSED   = 2'd3;
  localparam logic [APB_ADDR_W-1:0] ADDR_HEADER   = APB_ADDR_W'(REG_HEADER * 4);
  localparam logic [APB_ADDR_W-1:0] ADDR_VERSION  = APB_ADDR_W'(REG_VERSION * 4);
  localparam int                    HOLD_CYCLES   = 400;
  localparam int                    IDLE_LIMIT    = 2000;
  localparam int                    SETTLE_CYCLES = 4;
  localparam int                    DRAIN_CYCLES  = 10;
  localparam int                    PHASE_ITEMS   = 70;
  localparam int                    PHASE_FRAMES  = 8;
  localparam int                    SQUEEZE_PAIRS = 60;

  typedef enum int {
    FR_GOOD, FR_CRC_BAD, FR_HDR_BAD, FR_VER_BAD, FR_SHORT, FR_LONG, FR_NOISE, FR_EDGES
  } frame_kind_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;   // [15:0] word
  logic [1:0]            s_axis_tuser  = FUNC_WORD;  // [1:0] func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [31:0] command, ref_a .. ref_f, then the four totals, 32 bits each
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0]            m_axis_tuser;   // [2:0] status
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int          fail_count;
  int          pending;
  int          checked;
  int          items_sent     = 0;
  int          frames_closed  = 0;
  int          settings_used  = 1;
  int          idle_cycles    = 0;
  bit          tx_idle_en     = 1'b0;
  bit          rx_idle_en     = 1'b0;
  bit          hold_req       = 1'b0;
  logic [15:0] cur_header     = HEADER_RESET;
  logic [15:0] cur_version    = VERSION_RESET;

  always #5 clk_i = ~clk_i;

  spi_frame_checker_crc16 u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sfc_report_checker #(.FRAME_WORDS(FW)) u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_user_i(s_axis_tuser),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_user_i(m_axis_tuser),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // Receiver: random short stalls, plus one long hold when asked for.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Timeout: no item accepted for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Called and returning at a falling edge; valid stays high between items unless idle gaps are enabled.
  task automatic send_item(input logic [1:0] fn, input logic [15:0] w);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [15:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop offering, then wait until every report is in and the pipe is empty.
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] hdr, input logic [15:0] ver);
    drain_reports();
    apb_write(ADDR_HEADER, hdr);
    apb_write(ADDR_VERSION, ver);
    cur_header  = hdr;
    cur_version = ver;
    settings_used++;
  endtask

  function automatic logic [15:0] any_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(input frame_kind_e kind);
    logic [15:0] words [FW];
    logic [15:0] crc;
    int          n_words;
    crc = CRC_INIT;
    for (int i = 0; i < FW - 1; i++) begin
      words[i] = any_word();
    end
    words[0] = cur_header;
    words[1] = cur_version;
    if (kind == FR_HDR_BAD) begin
      words[0] = words[0] ^ 16'($urandom_range(1, 65535));
    end
    if (kind == FR_VER_BAD) begin
      words[1] = words[1] ^ 16'($urandom_range(1, 65535));
    end
    for (int i = 0; i < FW - 1; i++) begin
      crc = crc16_byte(crc16_byte(crc, words[i][15:8]), words[i][7:0]);
    end
    words[FW-1] = crc;
    if (kind == FR_CRC_BAD) begin
      words[FW-1] = crc ^ 16'($urandom_range(1, 65535));
    end
    case (kind)
      FR_SHORT:   n_words = $urandom_range(0, FW - 1);
      FR_HDR_BAD: n_words = $urandom_range(1, FW);
      FR_VER_BAD: n_words = $urandom_range(2, FW);
      default:    n_words = FW;
    endcase
    if (kind == FR_NOISE) begin
      // Arbitrary kinds and words, then a rising edge to settle things.
      repeat ($urandom_range(3, 8)) send_item(2'($urandom_range(0, 3)), 16'($urandom));
    end else begin
      send_item(FUNC_CS_FALL, 16'($urandom));
      if (kind == FR_EDGES) begin
        send_item(FUNC_CS_FALL, 16'($urandom));
      end
      for (int i = 0; i < n_words; i++) begin
        send_item(FUNC_WORD, words[i]);
      end
      if (kind == FR_LONG) begin
        repeat ($urandom_range(1, 3)) send_item(FUNC_WORD, any_word());
      end
    end
    send_item(FUNC_CS_RISE, 16'($urandom));
    if (kind == FR_EDGES) begin
      send_item(FUNC_CS_RISE, 16'($urandom));
    end
    frames_closed++;
  endtask

  task automatic run_phase(input int n_items, input int n_frames);
    int          first_item;
    int          first_frame;
    int unsigned r;
    first_item  = items_sent;
    first_frame = frames_closed;
    while (items_sent - first_item < n_items || frames_closed - first_frame < n_frames) begin
      r = $urandom_range(0, 99);
      if (r < 40)       send_frame(FR_GOOD);
      else if (r < 50)  send_frame(FR_CRC_BAD);
      else if (r < 58)  send_frame(FR_HDR_BAD);
      else if (r < 66)  send_frame(FR_VER_BAD);
      else if (r < 78)  send_frame(FR_SHORT);
      else if (r < 86)  send_frame(FR_LONG);
      else if (r < 94)  send_frame(FR_NOISE);
      else              send_frame(FR_EDGES);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // Directed: stray edges and words, unused kind, repeated fall, bad header,
    // then a full good frame with one to three words past its length.
    send_item(FUNC_CS_RISE, 16'h0000);
    send_item(FUNC_WORD, 16'hFFFF);
    send_item(FUNC_UNUSED, 16'hFFFF);
    send_item(FUNC_CS_FALL, 16'h0000);
    send_item(FUNC_CS_FALL, 16'hFFFF);
    send_item(FUNC_WORD, 16'h0000);
    send_item(FUNC_CS_RISE, 16'hFFFF);
    send_frame(FR_LONG);

    run_phase(PHASE_ITEMS, PHASE_FRAMES);
    set_config(16'hFFFF, 16'h0000);
    run_phase(PHASE_ITEMS, PHASE_FRAMES);
    set_config(16'h0000, 16'hFFFF);
    run_phase(PHASE_ITEMS, PHASE_FRAMES);

    // Empty frames against a stalled receiver fill the block up.
    set_config(16'($urandom), 16'($urandom));
    hold_req = 1'b1;
    repeat (SQUEEZE_PAIRS) begin
      send_item(FUNC_CS_FALL, 16'($urandom));
      send_item(FUNC_CS_RISE, 16'($urandom));
      frames_closed++;
    end
    run_phase(PHASE_ITEMS, PHASE_FRAMES);

    set_config(16'($urandom), 16'($urandom));
    run_phase(PHASE_ITEMS, PHASE_FRAMES);
    set_config(16'($urandom), 16'($urandom));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_phase(PHASE_ITEMS, PHASE_FRAMES);

    drain_reports();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Sent %0d input items closing %0d frames under %0d header/version settings,",
             items_sent, frames_closed, settings_used);
    $display("including one long output stall; %0d report items were compared.", checked);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
